// ===== rtl/obb_pkg.sv =====
package obb_pkg;

	// Operation codes carried in the func field
	typedef enum logic [1:0] {
		FUNC_OFFER_SNAPSHOT = 2'd0,
		FUNC_QUEUE_EVENT    = 2'd1,
		FUNC_DRAINED        = 2'd2,
		FUNC_CLEAR_ALL      = 2'd3
	} func_t;

	// Verdict codes reported with every result
	typedef enum logic [1:0] {
		VERDICT_NONE       = 2'd0,
		VERDICT_DROP       = 2'd1,
		VERDICT_DISCONNECT = 2'd2
	} verdict_t;

	// Configuration register indexes
	localparam logic [1:0] REG_FRAME_SIZE_LIMIT  = 2'd0;
	localparam logic [1:0] REG_BACKLOG_LIMIT     = 2'd1;
	localparam logic [1:0] REG_DROP_STREAK_LIMIT = 2'd2;
	localparam logic [1:0] REG_DOWNSHIFT_LEVEL   = 2'd3;

	// Configuration reset values
	localparam logic [31:0] RST_FRAME_SIZE_LIMIT  = 32'h0001_0000;
	localparam logic [31:0] RST_BACKLOG_LIMIT     = 32'h0004_0000;
	localparam logic [15:0] RST_DROP_STREAK_LIMIT = 16'd8;
	localparam logic [31:0] RST_DOWNSHIFT_LEVEL   = 32'h0002_0000;

	typedef struct packed {
		logic [31:0] frame_size_limit;
		logic [31:0] backlog_limit;
		logic [15:0] drop_streak_limit;
		logic [31:0] downshift_level;
	} obb_cfg_t;

	typedef struct packed {
		logic [31:0] queued;
		logic [31:0] snap_bytes;
		logic [31:0] snap_frames;
		logic [31:0] streak;
		logic [31:0] dropped;
		logic [47:0] accepted_sum;
		logic [31:0] accepted_frames;
		logic [31:0] largest;
		logic [31:0] events;
	} obb_state_t;

	// Clamp a grown 34-bit sum to the 32-bit maximum
	function automatic logic [31:0] sat32(input logic [33:0] v);
		return (|v[33:32]) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// Saturating increment of a 32-bit counter
	function automatic logic [31:0] sat_inc32(input logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/obb_step.sv =====
module obb_step (
	input  obb_pkg::obb_state_t cur,
	input  obb_pkg::obb_cfg_t   cfg,
	input  obb_pkg::func_t      func,
	input  logic [31:0]         byte_count,
	output obb_pkg::obb_state_t nxt,
	output obb_pkg::verdict_t   verdict,
	output logic                over_half
);

	logic [32:0] fit_sum0;
	logic        oversize;
	logic        flush;
	logic [31:0] queued_fl;
	logic [31:0] stale;
	logic [32:0] fit_sum1;
	logic        nofit;
	logic [33:0] streak_raw;
	logic [31:0] streak_mid;
	logic        disc;
	logic        extra;
	logic [31:0] streak_fin;
	logic [33:0] drops_raw;
	logic [31:0] snap_base;
	logic [31:0] frames_base;
	logic [48:0] sum_raw;
	logic [31:0] taken;
	logic [31:0] from_snap;
	logic [31:0] snap_left;

	// Snapshot offer: flush decision, fit check and streak bookkeeping
	assign fit_sum0  = {1'b0, cur.queued} + {1'b0, byte_count};
	assign oversize  = byte_count > cfg.frame_size_limit;
	assign flush     = fit_sum0 > {1'b0, cfg.backlog_limit};
	assign queued_fl = flush ? cur.queued - cur.snap_bytes : cur.queued;
	assign stale     = flush ? cur.snap_frames : 32'd0;
	assign fit_sum1  = {1'b0, queued_fl} + {1'b0, byte_count};
	assign nofit     = fit_sum1 > {1'b0, cfg.backlog_limit};

	// Saturating adds compose, so stale and no-fit drops go in one sum
	assign streak_raw = {2'b00, cur.streak} + {2'b00, stale} + {33'd0, nofit};
	assign streak_mid = obb_pkg::sat32(streak_raw);
	assign disc       = streak_mid >= {16'd0, cfg.drop_streak_limit};
	assign extra      = disc & ~nofit;
	assign streak_fin = extra ? obb_pkg::sat_inc32(streak_mid) : streak_mid;
	assign drops_raw  = {2'b00, cur.dropped} + {2'b00, stale}
		+ {33'd0, nofit} + {33'd0, extra};

	assign snap_base   = flush ? 32'd0 : cur.snap_bytes;
	assign frames_base = flush ? 32'd0 : cur.snap_frames;
	assign sum_raw     = {1'b0, cur.accepted_sum} + {17'd0, byte_count};

	// Drain: take from the backlog, snapshots first
	assign taken     = (byte_count < cur.queued) ? byte_count : cur.queued;
	assign from_snap = (taken < cur.snap_bytes) ? taken : cur.snap_bytes;
	assign snap_left = cur.snap_bytes - from_snap;

	// Next state and verdict
	always_comb begin
		nxt     = cur;
		verdict = obb_pkg::VERDICT_NONE;
		unique case (func)
			obb_pkg::FUNC_OFFER_SNAPSHOT: begin
				if (oversize) begin
					nxt.dropped = obb_pkg::sat_inc32(cur.dropped);
					nxt.streak  = obb_pkg::sat_inc32(cur.streak);
					verdict     = obb_pkg::VERDICT_DROP;
				end else begin
					nxt.queued      = queued_fl;
					nxt.snap_bytes  = snap_base;
					nxt.snap_frames = frames_base;
					nxt.streak      = streak_fin;
					nxt.dropped     = obb_pkg::sat32(drops_raw);
					if (disc) begin
						verdict = obb_pkg::VERDICT_DISCONNECT;
					end else if (nofit) begin
						verdict = obb_pkg::VERDICT_DROP;
					end else begin
						nxt.queued          = fit_sum1[31:0];
						nxt.snap_bytes      = snap_base + byte_count;
						nxt.snap_frames     = obb_pkg::sat_inc32(frames_base);
						nxt.accepted_sum    = sum_raw[48] ? 48'hFFFF_FFFF_FFFF
							: sum_raw[47:0];
						nxt.accepted_frames = obb_pkg::sat_inc32(cur.accepted_frames);
						if (byte_count > cur.largest) begin
							nxt.largest = byte_count;
						end
					end
				end
			end
			obb_pkg::FUNC_QUEUE_EVENT: begin
				nxt.queued = fit_sum0[32] ? 32'hFFFF_FFFF : fit_sum0[31:0];
				nxt.events = obb_pkg::sat_inc32(cur.events);
			end
			obb_pkg::FUNC_DRAINED: begin
				nxt.queued     = cur.queued - taken;
				nxt.snap_bytes = snap_left;
				if (snap_left == 32'd0) begin
					nxt.snap_frames = 32'd0;
				end else if (from_snap != 32'd0 && cur.snap_frames != 32'd0) begin
					nxt.snap_frames = cur.snap_frames - 32'd1;
				end
				nxt.streak = 32'd0;
			end
			obb_pkg::FUNC_CLEAR_ALL: begin
				nxt = '0;
			end
		endcase
	end

	assign over_half = nxt.queued > cfg.downshift_level;

endmodule

// ===== rtl/outbound_backlog_budget.sv =====
// A transaction passes from the input register to the result register once the result
// slot is empty or being taken, and its result then waits there until it is taken.
// Throughput: one transaction per cycle; the input register and the result
// register advance together whenever the result slot is empty or being taken.
// Reset (arst_n low, asynchronous): all counters and backlog state clear to zero,
// configuration registers return to their documented defaults, both stages empty.
module outbound_backlog_budget (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] byte_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict,
	output logic [31:0] queued_total,
	output logic        over_half,
	output logic [31:0] drop_total,
	output logic [31:0] drop_streak,
	output logic [47:0] accepted_bytes_sum,
	output logic [31:0] accepted_count,
	output logic [31:0] largest_frame,
	output logic [31:0] event_total
);

	obb_pkg::obb_cfg_t   cfg_q;
	obb_pkg::obb_state_t state_q;
	obb_pkg::obb_state_t state_nxt;
	obb_pkg::verdict_t   verdict_nxt;
	obb_pkg::verdict_t   verdict_s2;
	logic                over_half_nxt;
	logic                over_half_s2;
	logic                valid_s1;
	logic [1:0]          func_s1;
	logic [31:0]         byte_count_s1;
	logic                valid_s2;
	logic                s1_move;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_size_limit  <= obb_pkg::RST_FRAME_SIZE_LIMIT;
			cfg_q.backlog_limit     <= obb_pkg::RST_BACKLOG_LIMIT;
			cfg_q.drop_streak_limit <= obb_pkg::RST_DROP_STREAK_LIMIT;
			cfg_q.downshift_level   <= obb_pkg::RST_DOWNSHIFT_LEVEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				obb_pkg::REG_FRAME_SIZE_LIMIT:  cfg_q.frame_size_limit  <= cfg_data;
				obb_pkg::REG_BACKLOG_LIMIT:     cfg_q.backlog_limit     <= cfg_data;
				obb_pkg::REG_DROP_STREAK_LIMIT: cfg_q.drop_streak_limit <= cfg_data[15:0];
				obb_pkg::REG_DOWNSHIFT_LEVEL:   cfg_q.downshift_level   <= cfg_data;
			endcase
		end
	end

	// Advance the input stage when the result slot is free or being taken
	assign s1_move  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | s1_move;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1       <= func;
			byte_count_s1 <= byte_count;
		end
	end

	obb_step u_step (
		.cur        (state_q),
		.cfg        (cfg_q),
		.func       (obb_pkg::func_t'(func_s1)),
		.byte_count (byte_count_s1),
		.nxt        (state_nxt),
		.verdict    (verdict_nxt),
		.over_half  (over_half_nxt)
	);

	// Accounting state, updated as each transaction lands in the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_move) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			verdict_s2   <= verdict_nxt;
			over_half_s2 <= over_half_nxt;
		end
	end

	// State holds while the result waits, so counters drive the ports directly
	assign out_valid          = valid_s2;
	assign verdict            = verdict_s2;
	assign over_half          = over_half_s2;
	assign queued_total       = state_q.queued;
	assign drop_total         = state_q.dropped;
	assign drop_streak        = state_q.streak;
	assign accepted_bytes_sum = state_q.accepted_sum;
	assign accepted_count     = state_q.accepted_frames;
	assign largest_frame      = state_q.largest;
	assign event_total        = state_q.events;

	// Snapshot bytes are always part of the queued total
	a_snap_within_queue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.snap_bytes <= state_q.queued)
		else $error("snapshot bytes exceed queued total");

	// A disconnect verdict comes only with a streak at or above the limit
	a_disconnect_streak: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && verdict_s2 == obb_pkg::VERDICT_DISCONNECT)
		|-> (state_q.streak >= {16'd0, cfg_q.drop_streak_limit}))
		else $error("disconnect verdict below streak limit");

	// A transaction enters an occupied input stage only as the stage empties
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |-> s1_move)
		else $error("input stage overwritten");

endmodule

// ===== verif/obb_budget_checker.sv =====
module obb_budget_checker
	import obb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] byte_count,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  verdict,
	input  logic [31:0] queued_total,
	input  logic        over_half,
	input  logic [31:0] drop_total,
	input  logic [31:0] drop_streak,
	input  logic [47:0] accepted_bytes_sum,
	input  logic [31:0] accepted_count,
	input  logic [31:0] largest_frame,
	input  logic [31:0] event_total,
	output int          errors,
	output int          reports_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] queued;
		logic        over_half;
		logic [31:0] drops;
		logic [31:0] streak;
		logic [47:0] acc_sum;
		logic [31:0] acc_count;
		logic [31:0] largest;
		logic [31:0] events;
	} budget_report_t;

	obb_cfg_t       limits;
	obb_state_t     acct;
	budget_report_t due_reports[$];

	function automatic logic [31:0] clamp32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [47:0] clamp48(logic [63:0] v);
		return (v > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
	endfunction

	// Charge n dropped frames to both the lifetime total and the streak
	function automatic void charge_drops(logic [31:0] n);
		acct.dropped = clamp32({32'd0, acct.dropped} + {32'd0, n});
		acct.streak  = clamp32({32'd0, acct.streak} + {32'd0, n});
	endfunction

	function automatic logic overflows(logic [31:0] sz);
		return ({1'b0, acct.queued} + {1'b0, sz}) > {1'b0, limits.backlog_limit};
	endfunction

	// Snapshot offer: size check, stale flush, fit check, streak check, enqueue
	function automatic verdict_t offer_frame(logic [31:0] sz);
		verdict_t v;
		logic [31:0] stale;
		v = VERDICT_NONE;
		if (sz > limits.frame_size_limit) begin
			charge_drops(32'd1);
			return VERDICT_DROP;
		end
		if (overflows(sz)) begin
			stale = acct.snap_frames;
			acct.queued = acct.queued - acct.snap_bytes;
			acct.snap_bytes = '0;
			acct.snap_frames = '0;
			charge_drops(stale);
		end
		if (overflows(sz)) begin
			charge_drops(32'd1);
			v = VERDICT_DROP;
		end
		if (acct.streak >= {16'd0, limits.drop_streak_limit}) begin
			if (v == VERDICT_NONE)
				charge_drops(32'd1);
			v = VERDICT_DISCONNECT;
		end else if (v == VERDICT_NONE) begin
			acct.queued = acct.queued + sz;
			acct.snap_bytes = acct.snap_bytes + sz;
			acct.snap_frames = clamp32({32'd0, acct.snap_frames} + 64'd1);
			acct.accepted_sum = clamp48({16'd0, acct.accepted_sum} + {32'd0, sz});
			acct.accepted_frames = clamp32({32'd0, acct.accepted_frames} + 64'd1);
			if (sz > acct.largest)
				acct.largest = sz;
		end
		return v;
	endfunction

	// Drained bytes come out of snapshots first
	function automatic void take_drained(logic [31:0] n);
		logic [31:0] taken;
		logic [31:0] from_snap;
		taken = (n < acct.queued) ? n : acct.queued;
		from_snap = (taken < acct.snap_bytes) ? taken : acct.snap_bytes;
		acct.queued = acct.queued - taken;
		acct.snap_bytes = acct.snap_bytes - from_snap;
		if (from_snap != 0 && acct.snap_frames != 0)
			acct.snap_frames = acct.snap_frames - 32'd1;
		if (acct.snap_bytes == 0)
			acct.snap_frames = '0;
		acct.streak = '0;
	endfunction

	function automatic budget_report_t account_op(func_t op, logic [31:0] n);
		budget_report_t r;
		r.verdict = VERDICT_NONE;
		case (op)
			FUNC_OFFER_SNAPSHOT: r.verdict = offer_frame(n);
			FUNC_QUEUE_EVENT: begin
				acct.queued = clamp32({32'd0, acct.queued} + {32'd0, n});
				acct.events = clamp32({32'd0, acct.events} + 64'd1);
			end
			FUNC_DRAINED: take_drained(n);
			default: acct = '0;
		endcase
		r.queued    = acct.queued;
		r.over_half = acct.queued > limits.downshift_level;
		r.drops     = acct.dropped;
		r.streak    = acct.streak;
		r.acc_sum   = acct.accepted_sum;
		r.acc_count = acct.accepted_frames;
		r.largest   = acct.largest;
		r.events    = acct.events;
		return r;
	endfunction

	function automatic void compare_field(string what, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
				$time, what, want, got);
		end
	endfunction

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		budget_report_t want;
		if (!arst_n) begin
			limits.frame_size_limit  = RST_FRAME_SIZE_LIMIT;
			limits.backlog_limit     = RST_BACKLOG_LIMIT;
			limits.drop_streak_limit = RST_DROP_STREAK_LIMIT;
			limits.downshift_level   = RST_DOWNSHIFT_LEVEL;
			acct = '0;
			due_reports.delete();
			errors = 0;
			reports_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FRAME_SIZE_LIMIT:  limits.frame_size_limit = cfg_data;
					REG_BACKLOG_LIMIT:     limits.backlog_limit = cfg_data;
					REG_DROP_STREAK_LIMIT: limits.drop_streak_limit = cfg_data[15:0];
					default:               limits.downshift_level = cfg_data;
				endcase
			end
			// Check the result transaction against the oldest prediction
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none actual verdict %0d queued 0x%0h",
						$time, verdict, queued_total);
				end else begin
					want = due_reports.pop_front();
					compare_field("verdict", want.verdict, verdict);
					compare_field("queued_total", want.queued, queued_total);
					compare_field("over_half", want.over_half, over_half);
					compare_field("drop_total", want.drops, drop_total);
					compare_field("drop_streak", want.streak, drop_streak);
					compare_field("accepted_bytes_sum", want.acc_sum, accepted_bytes_sum);
					compare_field("accepted_count", want.acc_count, accepted_count);
					compare_field("largest_frame", want.largest, largest_frame);
					compare_field("event_total", want.events, event_total);
				end
			end
			// Predict the result of an accepted input transaction
			if (in_valid && in_ready)
				due_reports.push_back(account_op(func_t'(func), byte_count));
			reports_due = due_reports.size();
		end
	end

endmodule

// ===== verif/outbound_backlog_budget_tb.sv =====
module outbound_backlog_budget_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 150;
	localparam int PHASES = 7;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	func_t       func;
	logic [31:0] byte_count;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  verdict;
	logic [31:0] queued_total;
	logic        over_half;
	logic [31:0] drop_total;
	logic [31:0] drop_streak;
	logic [47:0] accepted_bytes_sum;
	logic [31:0] accepted_count;
	logic [31:0] largest_frame;
	logic [31:0] event_total;

	int          errors;
	int          reports_due;
	int          idle_cycles;
	int          sender_pct;
	int          stall_pct;
	logic [31:0] cur_frame;
	logic [31:0] cur_backlog;

	outbound_backlog_budget dut (.*);

	obb_budget_checker u_checker (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Receiver backpressure
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic set_idle(idle_mode_t mode);
		sender_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 11 : 0;
		stall_pct  = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 11 : 0;
	endtask

	// Hold one transaction until the block takes it
	task automatic send_op(func_t op, logic [31:0] n);
		while ($urandom_range(0, 99) < sender_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		byte_count <= n;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic wait_quiet();
		in_valid <= 1'b0;
		do @(negedge clk); while (reports_due != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_limits(logic [31:0] fsl, logic [31:0] bl, logic [31:0] dsl,
			logic [31:0] dl);
		write_reg(REG_FRAME_SIZE_LIMIT, fsl);
		write_reg(REG_BACKLOG_LIMIT, bl);
		write_reg(REG_DROP_STREAK_LIMIT, dsl);
		write_reg(REG_DOWNSHIFT_LEVEL, dl);
		cfg_we <= 1'b0;
		cur_frame = fsl;
		cur_backlog = bl;
	endtask

	// Byte counts mostly sized to the current limits, with edges and noise
	function automatic logic [31:0] pick_bytes();
		logic [31:0] scale;
		scale = (cur_frame < cur_backlog) ? cur_frame : cur_backlog;
		case ($urandom_range(0, 15))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom();
			3: return cur_frame + $urandom_range(0, 2) - 32'd1;
			4: return cur_backlog - $urandom_range(0, 2);
			default: return $urandom_range(0, scale);
		endcase
	endfunction

	initial begin
		logic [31:0] junk;
		logic [31:0] bl;
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FRAME_SIZE_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_OFFER_SNAPSHOT;
		byte_count = '0;
		out_ready = 1'b0;
		idle_cycles = 0;
		cur_frame = RST_FRAME_SIZE_LIMIT;
		cur_backlog = RST_BACKLOG_LIMIT;
		set_idle(IDLE_NONE);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sequence under the reset limits
		send_op(FUNC_OFFER_SNAPSHOT, 32'd0);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65536);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65537);      // oversize
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65536);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65536);      // above downshift level
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65536);      // backlog exactly full
		send_op(FUNC_OFFER_SNAPSHOT, 32'd1);          // flush stale snapshots, then fit
		send_op(FUNC_OFFER_SNAPSHOT, 32'd65537);
		send_op(FUNC_OFFER_SNAPSHOT, 32'hFFFF_FFFF);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd1);          // fits but streak disconnects
		send_op(FUNC_QUEUE_EVENT, 32'hFFFF_FFFF);     // backlog saturates
		send_op(FUNC_OFFER_SNAPSHOT, 32'd10);         // flush, still no room
		send_op(FUNC_DRAINED, 32'hFFFF_FFFF);         // drain beyond backlog
		send_op(FUNC_QUEUE_EVENT, 32'd50);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd30);
		send_op(FUNC_DRAINED, 32'd40);                // empties snapshot bytes
		send_op(FUNC_OFFER_SNAPSHOT, 32'd20);
		send_op(FUNC_OFFER_SNAPSHOT, 32'd20);
		send_op(FUNC_DRAINED, 32'd10);                // partial snapshot drain
		send_op(FUNC_CLEAR_ALL, 32'd0);
		send_op(FUNC_DRAINED, 32'd5);
		wait_quiet();

		// Random phases, each with its own limits and idling
		for (int ph = 0; ph < PHASES; ph++) begin
			junk = $urandom();
			case (ph)
				0: load_limits(32'd1, 32'd1, 32'd1, 32'd0);
				1: load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
				2: begin
					bl = $urandom_range(1, 12000);
					load_limits($urandom_range(1, 3000), bl, {junk[31:16], 16'd0},
						$urandom_range(0, bl));
				end
				default: begin
					bl = $urandom_range(1, 20000);
					load_limits($urandom_range(1, 5000), bl,
						{junk[31:16], 16'($urandom_range(1, 10))}, $urandom_range(0, bl));
				end
			endcase
			set_idle(idle_mode_t'(ph % 4));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 50)
					send_op(FUNC_OFFER_SNAPSHOT, pick_bytes());
				else if (pick < 65)
					send_op(FUNC_QUEUE_EVENT, pick_bytes());
				else if (pick < 94)
					send_op(FUNC_DRAINED, pick_bytes());
				else
					send_op(FUNC_CLEAR_ALL, $urandom());
			end
			wait_quiet();
		end

		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
